>>> rtl/riscv_trap_entry_unit_top_assert.svh
// ============================================================================
// Trap entry unit assertion macros
// Immediate and next-cycle implication checks, compiled out under SYNTH.
// ============================================================================
`ifndef RISCV_TRAP_ENTRY_UNIT_TOP_ASSERT_SVH
`define RISCV_TRAP_ENTRY_UNIT_TOP_ASSERT_SVH
`ifndef SYNTH
`define RTE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trap entry check failed");
`define RTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trap entry check failed");
`else
`define RTE_ASSERT_NOW(label, clk, rst, ante, cons)
`define RTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rte_pkg.sv
// ============================================================================
// Trap entry unit package
// Shared types, mstatus field positions, cause numbers and register map.
// ============================================================================
`default_nettype none

package rte_pkg;

   localparam logic       CMD_RAISE = 1'b0;

   localparam logic [1:0] MODE_U = 2'd0;
   localparam logic [1:0] MODE_S = 2'd1;
   localparam logic [1:0] MODE_M = 2'd3;

   localparam int ST_SIE  = 1;
   localparam int ST_MIE  = 3;
   localparam int ST_SPIE = 5;
   localparam int ST_MPIE = 7;
   localparam int ST_SPP  = 8;
   localparam int ST_MPP  = 11;

   localparam logic [1:0] VEC_VECTORED = 2'd1;

   localparam logic [5:0] CAUSE_SSI = 6'd1;
   localparam logic [5:0] CAUSE_MSI = 6'd3;
   localparam logic [5:0] CAUSE_STI = 6'd5;
   localparam logic [5:0] CAUSE_MTI = 6'd7;
   localparam logic [5:0] CAUSE_SEI = 6'd9;
   localparam logic [5:0] CAUSE_MEI = 6'd11;

   // pending scan priority, entry 0 first
   localparam int SCAN_N = 6;
   localparam logic [SCAN_N-1:0][5:0] SCAN_CAUSE =
      {CAUSE_STI, CAUSE_SSI, CAUSE_SEI, CAUSE_MTI, CAUSE_MSI, CAUSE_MEI};

   localparam int CSR_ADDR_W = 6;
   localparam logic [2:0] REG_MTVEC   = 3'd0;
   localparam logic [2:0] REG_STVEC   = 3'd1;
   localparam logic [2:0] REG_MEDELEG = 3'd2;
   localparam logic [2:0] REG_MIDELEG = 3'd3;
   localparam logic [2:0] REG_MIE     = 3'd4;
   localparam logic [2:0] REG_SIE     = 3'd5;

   typedef struct packed {
      logic [63:0] mtvec;
      logic [63:0] stvec;
      logic [63:0] medeleg;
      logic [63:0] mideleg;
      logic [63:0] mie;
      logic [63:0] sie;
   } rte_csr_type;

   typedef struct packed {
      logic        cmd;
      logic        is_interrupt;
      logic [5:0]  cause_code;
      logic [63:0] fault_value;
      logic [63:0] current_pc;
      logic [1:0]  current_mode;
      logic [63:0] status_in;
      logic [63:0] pending_bits;
   } rte_req_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } rte_ctl_type;

   typedef struct packed {
      logic        taken;
      logic        sup;
      logic        intr;
      logic [5:0]  cause;
      logic [63:0] tval;
      logic [63:0] pc;
      logic [1:0]  mode;
      logic [63:0] status;
   } rte_s1_type;

   typedef struct packed {
      logic        taken;
      logic        sup;
      logic [63:0] base;
      logic [7:0]  offset;
      logic [63:0] pc;
      logic [1:0]  next_mode;
      logic [63:0] status_out;
      logic [63:0] trap_cause;
      logic [63:0] trap_value;
   } rte_s2_type;

   typedef struct packed {
      logic        taken;
      logic        to_supervisor;
      logic [63:0] next_pc;
      logic [1:0]  next_mode;
      logic [63:0] status_out;
      logic [63:0] trap_cause;
      logic [63:0] exception_pc;
      logic [63:0] trap_value;
   } rte_rsp_type;

endpackage

`default_nettype wire

>>> rtl/rte_req_if.sv
// ============================================================================
// Trap entry request channel
// Valid/ready channel carrying one trap request.
// ============================================================================
`default_nettype none

interface rte_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic        is_interrupt;
   logic [5:0]  cause_code;
   logic [63:0] fault_value;
   logic [63:0] current_pc;
   logic [1:0]  current_mode;
   logic [63:0] status_in;
   logic [63:0] pending_bits;

   modport source (
      output valid, cmd, is_interrupt, cause_code, fault_value, current_pc,
             current_mode, status_in, pending_bits,
      input  ready
   );
   modport sink (
      input  valid, cmd, is_interrupt, cause_code, fault_value, current_pc,
             current_mode, status_in, pending_bits,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/rte_rsp_if.sv
// ============================================================================
// Trap entry response channel
// Valid/ready channel carrying one trap entry result.
// ============================================================================
`default_nettype none

interface rte_rsp_if;
   logic        valid;
   logic        ready;
   logic        taken;
   logic        to_supervisor;
   logic [63:0] next_pc;
   logic [1:0]  next_mode;
   logic [63:0] status_out;
   logic [63:0] trap_cause;
   logic [63:0] exception_pc;
   logic [63:0] trap_value;

   modport source (
      output valid, taken, to_supervisor, next_pc, next_mode, status_out,
             trap_cause, exception_pc, trap_value,
      input  ready
   );
   modport sink (
      input  valid, taken, to_supervisor, next_pc, next_mode, status_out,
             trap_cause, exception_pc, trap_value,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/rte_csr.sv
// ============================================================================
// Trap entry CSR block
// APB-style write/read port for trap vectors, delegation and enables.
// ============================================================================
`default_nettype none

module rte_csr import rte_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [63:0]           pwdata,
   output logic [63:0]                prdata,
   output logic                       pready,
   output rte_csr_type                regs
);

   rte_csr_type regs_ff;
   logic [2:0]  idx;

   assign idx    = paddr[CSR_ADDR_W-1:3];
   assign pready = 1'b1;
   assign regs   = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (idx)
            REG_MTVEC:   regs_ff.mtvec   <= pwdata;
            REG_STVEC:   regs_ff.stvec   <= pwdata;
            REG_MEDELEG: regs_ff.medeleg <= pwdata;
            REG_MIDELEG: regs_ff.mideleg <= pwdata;
            REG_MIE:     regs_ff.mie     <= pwdata;
            REG_SIE:     regs_ff.sie     <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MTVEC:   prdata = regs_ff.mtvec;
         REG_STVEC:   prdata = regs_ff.stvec;
         REG_MEDELEG: prdata = regs_ff.medeleg;
         REG_MIDELEG: prdata = regs_ff.mideleg;
         REG_MIE:     prdata = regs_ff.mie;
         REG_SIE:     prdata = regs_ff.sie;
         default:     prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/rte_select.sv
// ============================================================================
// Trap entry stage 1: trap selection
// Masking, delegation and pending-interrupt priority; picks the trap taken.
// ============================================================================
`default_nettype none

module rte_select import rte_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  rte_ctl_type      ctl,
   input  rte_req_type      req,
   input  rte_csr_type      regs,
   output logic             s1_valid,
   output rte_s1_type       s1
);

   // returns {ok, to_supervisor}
   function automatic logic [1:0] trap_check(
      input logic        intr,
      input logic [5:0]  cause,
      input logic [1:0]  mode,
      input logic [63:0] status,
      input rte_csr_type csr
   );
      logic m_masked;
      logic s_masked;
      logic dlg;
      logic sup;
      logic en;
      m_masked = intr && (mode == MODE_M) && !status[ST_MIE];
      s_masked = intr && (mode == MODE_S) && !status[ST_SIE] &&
                 (cause != CAUSE_MSI) && (cause != CAUSE_MTI) && (cause != CAUSE_MEI);
      dlg = intr ? csr.mideleg[cause] : csr.medeleg[cause];
      sup = dlg && ((mode == MODE_U) || (mode == MODE_S));
      en  = sup ? csr.sie[cause] : csr.mie[cause];
      return {!m_masked && !s_masked && (!intr || en), sup};
   endfunction

   logic                    s1_valid_ff;
   rte_s1_type              s1_ff;
   rte_s1_type              s1_in;
   logic [1:0]              chk_raise;
   logic [SCAN_N-1:0][1:0]  chk_scan;
   logic [SCAN_N-1:0]       hit;
   logic                    allow;

   always_comb begin
      chk_raise = trap_check(req.is_interrupt, req.cause_code, req.current_mode,
                             req.status_in, regs);
      allow = req.status_in[ST_MIE] || (req.current_mode != MODE_M);
      for (int i = 0; i < SCAN_N; i++) begin
         chk_scan[i] = trap_check(1'b1, SCAN_CAUSE[i], req.current_mode,
                                  req.status_in, regs);
         hit[i] = allow && req.pending_bits[SCAN_CAUSE[i]] && chk_scan[i][1];
      end

      s1_in.taken  = 1'b0;
      s1_in.sup    = 1'b0;
      s1_in.intr   = 1'b1;
      s1_in.cause  = '0;
      s1_in.tval   = '0;
      s1_in.pc     = req.current_pc;
      s1_in.mode   = req.current_mode;
      s1_in.status = req.status_in;

      for (int i = SCAN_N - 1; i >= 0; i--) begin
         if (hit[i]) begin
            s1_in.taken = 1'b1;
            s1_in.sup   = chk_scan[i][0];
            s1_in.cause = SCAN_CAUSE[i];
         end
      end

      if (req.cmd == CMD_RAISE) begin
         s1_in.taken = chk_raise[1];
         s1_in.sup   = chk_raise[0];
         s1_in.intr  = req.is_interrupt;
         s1_in.cause = req.cause_code;
         s1_in.tval  = req.fault_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         s1_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

`default_nettype wire

>>> rtl/rte_entry.sv
// ============================================================================
// Trap entry stage 2: state update
// mstatus field moves, vector base and offset, cause and value formatting.
// ============================================================================
`default_nettype none

module rte_entry import rte_pkg::*; #(
   parameter int XLEN = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  rte_ctl_type      ctl,
   input  rte_s1_type       s1,
   input  rte_csr_type      regs,
   output logic             s2_valid,
   output rte_s2_type       s2
);

   localparam logic [63:0] INT_FLAG = 64'd1 << (XLEN - 1);

   logic        s2_valid_ff;
   rte_s2_type  s2_ff;
   rte_s2_type  s2_in;
   logic [63:0] vec;
   logic [63:0] st;
   logic [63:0] cause_full;

   always_comb begin
      vec = s1.sup ? regs.stvec : regs.mtvec;
      st  = s1.status;
      if (s1.sup) begin
         st[ST_SPP +: 2] = s1.mode;
         st[ST_SPIE]     = st[ST_SIE];
         st[ST_SIE]      = 1'b0;
      end else begin
         st[ST_MPP +: 2] = s1.mode;
         st[ST_MPIE]     = st[ST_MIE];
         st[ST_MIE]      = 1'b0;
      end
      cause_full = {58'd0, s1.cause} | (s1.intr ? INT_FLAG : 64'd0);

      s2_in.taken  = s1.taken;
      s2_in.sup    = s1.sup;
      s2_in.base   = {vec[63:2], 2'b00};
      s2_in.offset = (s1.intr && (vec[1:0] == VEC_VECTORED)) ? {s1.cause, 2'b00} : 8'd0;
      s2_in.pc     = s1.pc;
      if (s1.taken) begin
         s2_in.next_mode  = s1.sup ? MODE_S : MODE_M;
         s2_in.status_out = st;
         s2_in.trap_cause = cause_full;
         s2_in.trap_value = s1.tval;
      end else begin
         s2_in.next_mode  = s1.mode;
         s2_in.status_out = s1.status;
         s2_in.trap_cause = '0;
         s2_in.trap_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         s2_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

`default_nettype wire

>>> rtl/riscv_trap_entry_unit_top.sv
// ============================================================================
// RISC-V trap entry unit
// Three-stage trap entry with M/S delegation and pending-interrupt scan.
// ============================================================================
// Requests arrive on req_if (valid/ready) with pc, mode, mstatus and mip,
// either raising one trap or asking for a pending-interrupt scan. Every
// request yields exactly one response on rsp_if.
// An accepted request passes the select, entry update and pc add/output
// registers to rsp_if.valid; one request per cycle unless rsp_if stalls.
// Trap vectors, delegation and enable masks sit behind the APB port at
// byte address 8*index; write them only while the pipeline is empty.
// Reset clears all stage valids and the CSRs; req_if.ready is low during
// reset. When rsp_if.ready is low the output register holds; upstream
// stages keep filling and req_if.ready drops once all three are full.
// ============================================================================
`default_nettype none
`include "riscv_trap_entry_unit_top_assert.svh"

module riscv_trap_entry_unit_top import rte_pkg::*; #(
   parameter int XLEN = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rte_req_if.sink                    req_if,
   rte_rsp_if.source                  rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [63:0]           pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);

   localparam logic [63:0] PC_MASK = {64{1'b1}} >> (64 - XLEN);

   rte_csr_type regs;
   rte_req_type req;
   rte_ctl_type ctl1;
   rte_ctl_type ctl2;
   logic        s1_valid;
   logic        s2_valid;
   rte_s1_type  s1;
   rte_s2_type  s2;
   logic        adv_out;
   logic        rsp_valid_ff;
   rte_rsp_type rsp_ff;
   rte_rsp_type rsp_in;

   rte_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   assign req.cmd          = req_if.cmd;
   assign req.is_interrupt = req_if.is_interrupt;
   assign req.cause_code   = req_if.cause_code;
   assign req.fault_value  = req_if.fault_value;
   assign req.current_pc   = req_if.current_pc;
   assign req.current_mode = req_if.current_mode;
   assign req.status_in    = req_if.status_in;
   assign req.pending_bits = req_if.pending_bits;

   assign adv_out       = !rsp_valid_ff || rsp_if.ready;
   assign ctl2.advance  = !s2_valid || adv_out;
   assign ctl2.valid    = s1_valid;
   assign ctl1.advance  = !s1_valid || ctl2.advance;
   assign ctl1.valid    = req_if.valid && !reset;
   assign req_if.ready  = ctl1.advance && !reset;

   rte_select u_select (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl1),
      .req      (req),
      .regs     (regs),
      .s1_valid (s1_valid),
      .s1       (s1)
   );

   rte_entry #(
      .XLEN (XLEN)
   ) u_entry (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl2),
      .s1       (s1),
      .regs     (regs),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   always_comb begin
      rsp_in.taken         = s2.taken;
      rsp_in.to_supervisor = s2.taken && s2.sup;
      rsp_in.next_pc       = s2.taken ? ((s2.base + {56'd0, s2.offset}) & PC_MASK) : s2.pc;
      rsp_in.next_mode     = s2.next_mode;
      rsp_in.status_out    = s2.status_out;
      rsp_in.trap_cause    = s2.trap_cause;
      rsp_in.exception_pc  = s2.taken ? s2.pc : 64'd0;
      rsp_in.trap_value    = s2.trap_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.taken         = rsp_ff.taken;
   assign rsp_if.to_supervisor = rsp_ff.to_supervisor;
   assign rsp_if.next_pc       = rsp_ff.next_pc;
   assign rsp_if.next_mode     = rsp_ff.next_mode;
   assign rsp_if.status_out    = rsp_ff.status_out;
   assign rsp_if.trap_cause    = rsp_ff.trap_cause;
   assign rsp_if.exception_pc  = rsp_ff.exception_pc;
   assign rsp_if.trap_value    = rsp_ff.trap_value;

   `RTE_ASSERT_NOW(a_full_stall, clock, reset, s1_valid && s2_valid && rsp_valid_ff && !rsp_if.ready, !req_if.ready)
   `RTE_ASSERT_NEXT(a_accept_fills, clock, reset, req_if.valid && req_if.ready, s1_valid)
   `RTE_ASSERT_NOW(a_sup_mode, clock, reset, rsp_valid_ff && rsp_ff.to_supervisor, rsp_ff.taken && (rsp_ff.next_mode == MODE_S))
   `RTE_ASSERT_NOW(a_idle_zero, clock, reset, rsp_valid_ff && !rsp_ff.taken, (rsp_ff.trap_cause == 64'd0) && (rsp_ff.exception_pc == 64'd0))

endmodule

`default_nettype wire

>>> sim/riscv_trap_entry_unit_checker.sv
// ============================================================================
// Trap entry unit checker
// Watches the request, response and APB ports, predicts each trap entry
// from a register shadow, and compares responses in order.
// ============================================================================
`default_nettype none

module riscv_trap_entry_unit_checker import rte_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rte_req_if                         req_mon,
   rte_rsp_if                         rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [63:0]           pwdata,
   input  wire logic                  pready,
   output int                         fail_count,
   output int                         pending_count,
   output int                         request_count,
   output int                         taken_count,
   output int                         deleg_count
);
   timeunit 1ns;
   timeprecision 1ps;

   rte_csr_type csr_shadow;
   rte_rsp_type entry_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      request_count = 0;
      taken_count   = 0;
      deleg_count   = 0;
      csr_shadow    = '0;
   end

   function automatic logic enter_trap(input logic intr, input logic [5:0] cause,
                                       input logic [63:0] tval, input logic [63:0] pc,
                                       input logic [1:0] mode, input logic [63:0] status,
                                       output rte_rsp_type r);
      logic [63:0] deleg;
      logic [63:0] vec;
      logic [63:0] st;
      logic        sup;
      r = '0;
      st = status;
      deleg = intr ? csr_shadow.mideleg : csr_shadow.medeleg;
      if (intr && mode == MODE_M && !st[ST_MIE]) return 1'b0;
      if (intr && mode == MODE_S && !st[ST_SIE] && cause != CAUSE_MSI &&
          cause != CAUSE_MTI && cause != CAUSE_MEI) return 1'b0;
      sup = deleg[cause] && mode <= MODE_S;
      if (sup) begin
         if (intr && !csr_shadow.sie[cause]) return 1'b0;
         st[ST_SPP +: 2] = mode;
         st[ST_SPIE] = st[ST_SIE];
         st[ST_SIE] = 1'b0;
         vec = csr_shadow.stvec;
      end else begin
         if (intr && !csr_shadow.mie[cause]) return 1'b0;
         st[ST_MPP +: 2] = mode;
         st[ST_MPIE] = st[ST_MIE];
         st[ST_MIE] = 1'b0;
         vec = csr_shadow.mtvec;
      end
      r.taken = 1'b1;
      r.to_supervisor = sup;
      r.next_pc = {vec[63:2], 2'b00};
      if (intr && vec[1:0] == VEC_VECTORED) r.next_pc += {56'd0, cause, 2'b00};
      r.next_mode = sup ? MODE_S : MODE_M;
      r.status_out = st;
      r.trap_cause = {intr, 57'd0, cause};
      r.exception_pc = pc;
      r.trap_value = tval;
      return 1'b1;
   endfunction

   function automatic rte_rsp_type predict_trap_entry(input rte_req_type q);
      rte_rsp_type r;
      rte_rsp_type hit_r;
      logic        hit;
      r = '0;
      r.next_pc = q.current_pc;
      r.next_mode = q.current_mode;
      r.status_out = q.status_in;
      hit = 1'b0;
      if (q.cmd == CMD_RAISE) begin
         hit = enter_trap(q.is_interrupt, q.cause_code, q.fault_value, q.current_pc,
                          q.current_mode, q.status_in, hit_r);
      end else begin
         if ((q.status_in[ST_MIE] || q.current_mode != MODE_M) && q.pending_bits != '0)
            for (int i = 0; i < SCAN_N; i++)
               if (!hit && q.pending_bits[SCAN_CAUSE[i]])
                  hit = enter_trap(1'b1, SCAN_CAUSE[i], 64'd0, q.current_pc,
                                   q.current_mode, q.status_in, hit_r);
         // second pass retries the supervisor causes only
         if (!hit && q.status_in[ST_SIE] && q.pending_bits != '0)
            for (int i = SCAN_N - 3; i < SCAN_N; i++)
               if (!hit && q.pending_bits[SCAN_CAUSE[i]])
                  hit = enter_trap(1'b1, SCAN_CAUSE[i], 64'd0, q.current_pc,
                                   q.current_mode, q.status_in, hit_r);
      end
      return hit ? hit_r : r;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rte_req_type q;
      rte_rsp_type e;
      if (reset) begin
         csr_shadow = '0;
         entry_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:3])
               REG_MTVEC:   csr_shadow.mtvec   = pwdata;
               REG_STVEC:   csr_shadow.stvec   = pwdata;
               REG_MEDELEG: csr_shadow.medeleg = pwdata;
               REG_MIDELEG: csr_shadow.mideleg = pwdata;
               REG_MIE:     csr_shadow.mie     = pwdata;
               REG_SIE:     csr_shadow.sie     = pwdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            q.cmd          = req_mon.cmd;
            q.is_interrupt = req_mon.is_interrupt;
            q.cause_code   = req_mon.cause_code;
            q.fault_value  = req_mon.fault_value;
            q.current_pc   = req_mon.current_pc;
            q.current_mode = req_mon.current_mode;
            q.status_in    = req_mon.status_in;
            q.pending_bits = req_mon.pending_bits;
            e = predict_trap_entry(q);
            entry_q.push_back(e);
            request_count++;
            if (e.taken) taken_count++;
            if (e.to_supervisor) deleg_count++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (entry_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request outstanding, next_pc %h",
                        $time, rsp_mon.next_pc);
            end else begin
               e = entry_q.pop_front();
               check_field("taken",         e.taken,         rsp_mon.taken);
               check_field("to_supervisor", e.to_supervisor, rsp_mon.to_supervisor);
               check_field("next_pc",       e.next_pc,       rsp_mon.next_pc);
               check_field("next_mode",     e.next_mode,     rsp_mon.next_mode);
               check_field("status_out",    e.status_out,    rsp_mon.status_out);
               check_field("trap_cause",    e.trap_cause,    rsp_mon.trap_cause);
               check_field("exception_pc",  e.exception_pc,  rsp_mon.exception_pc);
               check_field("trap_value",    e.trap_value,    rsp_mon.trap_value);
            end
         end
      end
      pending_count = entry_q.size();
   end

endmodule

`default_nettype wire

>>> sim/riscv_trap_entry_unit_top_tb.sv
// ============================================================================
// Trap entry unit testbench
// Directed trap and interrupt-scan requests, then random phases under
// several register settings and idle patterns; the checker scores results.
// ============================================================================
`default_nettype none

module riscv_trap_entry_unit_top_tb import rte_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       CMD_SCAN  = ~CMD_RAISE;
   localparam logic [1:0] MODE_RSVD = 2'd2;
   localparam int         PHASES    = 8;
   localparam int         PHASE_LEN = 155;
   localparam int         HOLD_LEN  = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [63:0]           pwdata;
   logic [63:0]           prdata;
   logic                  pready;
   logic                  drain_ready = 1'b0;
   logic                  drain_hold = 1'b0;
   int                    offer_gap_pct = 0;
   int                    drain_stall_pct = 0;
   int                    settings_count = 0;
   int                    fail_count;
   int                    pending_count;
   int                    request_count;
   int                    taken_count;
   int                    deleg_count;

   rte_req_if req_if ();
   rte_rsp_if rsp_if ();

   assign rsp_if.ready = drain_ready;

   riscv_trap_entry_unit_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   riscv_trap_entry_unit_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .request_count (request_count),
      .taken_count   (taken_count),
      .deleg_count   (deleg_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      drain_ready <= !drain_hold && ($urandom_range(99) >= drain_stall_pct);
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d requests outstanding", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic rte_req_type make_req(input logic cmd, input logic intr,
                                            input logic [5:0] cause,
                                            input logic [63:0] tval, input logic [63:0] pc,
                                            input logic [1:0] mode,
                                            input logic [63:0] status,
                                            input logic [63:0] mip);
      rte_req_type q;
      q.cmd = cmd;
      q.is_interrupt = intr;
      q.cause_code = cause;
      q.fault_value = tval;
      q.current_pc = pc;
      q.current_mode = mode;
      q.status_in = status;
      q.pending_bits = mip;
      return q;
   endfunction

   function automatic rte_req_type random_request();
      rte_req_type q;
      q.cmd = ($urandom_range(99) < 45) ? CMD_SCAN : CMD_RAISE;
      q.is_interrupt = 1'($urandom_range(1));
      if ($urandom_range(3) == 0)
         q.cause_code = 6'($urandom_range(63));
      else if (q.is_interrupt)
         q.cause_code = SCAN_CAUSE[3'($urandom_range(SCAN_N-1))];
      else
         q.cause_code = 6'($urandom_range(15));
      q.fault_value = random_word();
      q.current_pc = random_word();
      case ($urandom_range(9))
         0:       q.current_mode = MODE_RSVD;
         1, 2, 3: q.current_mode = MODE_U;
         4, 5, 6: q.current_mode = MODE_S;
         default: q.current_mode = MODE_M;
      endcase
      q.status_in = random_word();
      case ($urandom_range(5))
         0: q.pending_bits = '0;
         1: q.pending_bits = random_word();
         default: begin
            q.pending_bits = '0;
            for (int i = 0; i < SCAN_N; i++)
               if ($urandom_range(2) == 0) q.pending_bits[SCAN_CAUSE[i]] = 1'b1;
            if ($urandom_range(3) == 0) q.pending_bits[6'($urandom_range(63))] = 1'b1;
         end
      endcase
      return q;
   endfunction

   function automatic rte_csr_type random_settings();
      rte_csr_type s;
      s.mtvec   = random_word();
      s.stvec   = random_word();
      s.mtvec[1:0] = ($urandom_range(3) != 0) ? VEC_VECTORED : 2'($urandom_range(3));
      s.stvec[1:0] = ($urandom_range(3) != 0) ? VEC_VECTORED : 2'($urandom_range(3));
      s.medeleg = random_word();
      s.mideleg = random_word();
      s.mie     = random_word() | random_word();
      s.sie     = random_word() | random_word();
      return s;
   endfunction

   // caller is at a falling edge; returns at a falling edge with psel still high
   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_settings(input rte_csr_type s);
      write_csr(REG_MTVEC,   s.mtvec);
      write_csr(REG_STVEC,   s.stvec);
      write_csr(REG_MEDELEG, s.medeleg);
      write_csr(REG_MIDELEG, s.mideleg);
      write_csr(REG_MIE,     s.mie);
      write_csr(REG_SIE,     s.sie);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      settings_count++;
   endtask

   task automatic send_request(input rte_req_type q);
      while (offer_gap_pct != 0 && $urandom_range(99) < offer_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= q.cmd;
      req_if.is_interrupt <= q.is_interrupt;
      req_if.cause_code   <= q.cause_code;
      req_if.fault_value  <= q.fault_value;
      req_if.current_pc   <= q.current_pc;
      req_if.current_mode <= q.current_mode;
      req_if.status_in    <= q.status_in;
      req_if.pending_bits <= q.pending_bits;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      rte_csr_type s;
      logic [63:0] ones;
      int          waited;
      ones = '1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_RAISE;
      req_if.is_interrupt = 1'b0;
      req_if.cause_code   = '0;
      req_if.fault_value  = '0;
      req_if.current_pc   = '0;
      req_if.current_mode = MODE_M;
      req_if.status_in    = '0;
      req_if.pending_bits = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: wrap-around vector bases, partial delegation, holes in enables
      s.mtvec   = 64'hFFFF_FFFF_FFFF_FFF1;
      s.stvec   = 64'hFFFF_FFFF_FFFF_FF01;
      s.medeleg = 64'h0000_0000_0000_B100;
      s.mideleg = 64'h8000_0000_0000_0222;
      s.mie     = ~(64'd1 << 13);
      s.sie     = ~(64'd1 << CAUSE_STI);
      load_settings(s);
      send_request(make_req(CMD_RAISE, 0, 6'd2,  64'h1234, 64'h8000_0000, MODE_M, 0, 0));
      send_request(make_req(CMD_RAISE, 0, 6'd8,  64'h55, 64'h8000_0004, MODE_U, 64'h2, 0));
      send_request(make_req(CMD_RAISE, 0, 6'd8,  64'h66, 64'h8000_0008, MODE_M, 64'h8, 0));
      send_request(make_req(CMD_RAISE, 0, 6'd8,  64'h77, 64'h8000_000C, MODE_RSVD, 0, 0));
      send_request(make_req(CMD_RAISE, 0, 6'd0,  ones, ones, MODE_S, ones, ones));
      send_request(make_req(CMD_RAISE, 0, 6'd63, 0, 0, MODE_U, 0, 0));
      send_request(make_req(CMD_RAISE, 1, CAUSE_MTI, 0, 64'h100, MODE_M, 64'h8, 0));
      send_request(make_req(CMD_RAISE, 1, CAUSE_MTI, 0, 64'h104, MODE_M, 0, 0));
      send_request(make_req(CMD_RAISE, 1, CAUSE_MSI, 0, 64'h108, MODE_S, 0, 0));
      send_request(make_req(CMD_RAISE, 1, CAUSE_STI, 0, 64'h10C, MODE_S, 0, 0));
      send_request(make_req(CMD_RAISE, 1, CAUSE_SEI, 0, 64'h110, MODE_S, 64'h2, 0));
      send_request(make_req(CMD_RAISE, 1, CAUSE_STI, 0, 64'h114, MODE_U, 0, 0));
      send_request(make_req(CMD_RAISE, 1, 6'd13, 0, 64'h118, MODE_U, 0, 0));
      send_request(make_req(CMD_RAISE, 1, 6'd63, ones, 64'h11C, MODE_U, 0, 0));
      send_request(make_req(CMD_RAISE, 1, 6'd2,  0, 64'h120, MODE_RSVD, 0, 0));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h200, MODE_U, ones, 0));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h204, MODE_U, 0, ones));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h208, MODE_M, 64'h8, 64'h202));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h20C, MODE_M, 64'h2, 64'h200));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h210, MODE_U, 0, 64'h22));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h214, MODE_U, 0, 64'h20));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h218, MODE_U, ones,
                            64'h8000_0000_0000_2001));
      send_request(make_req(CMD_SCAN, 1, 6'd63, ones, 64'h21C, MODE_S, 64'h2, 64'h8));
      send_request(make_req(CMD_SCAN, 0, 0, 0, 64'h220, MODE_S, 64'h2, 64'h20));
      send_request(make_req(CMD_SCAN, 0, 0, 0, ones, MODE_RSVD, 0, ones));
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       s = '0;
            1:       s = {6{ones}};
            default: s = random_settings();
         endcase
         load_settings(s);
         case (phase % 4)
            0: begin offer_gap_pct = 0;  drain_stall_pct = 0;  end
            1: begin offer_gap_pct = 72; drain_stall_pct = 0;  end
            2: begin offer_gap_pct = 0;  drain_stall_pct = 72; end
            default: begin offer_gap_pct = 22; drain_stall_pct = 22; end
         endcase
         if (phase == 4) begin
            fork
               begin
                  drain_hold = 1'b1;
                  repeat (HOLD_LEN) @(negedge clock);
                  drain_hold = 1'b0;
               end
            join_none
         end
         repeat (PHASE_LEN) send_request(random_request());
         wait_drained();
      end

      waited = 0;
      while (pending_count != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      $display("Coverage: %0d requests under %0d register settings, four idle patterns",
               request_count, settings_count);
      $display("          %0d traps entered, %0d of them delegated to supervisor",
               taken_count, deleg_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, pending_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
